/* sv/prs_pkg.sv */
// ---------------------------------------------------------------------------
// prs_pkg: shared types and codes of the priority round robin scheduler
// Holds the table entry layout, the table write request and the status codes.
// ---------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

   // Entry phases.
   localparam logic [1:0] PH_EMPTY  = 2'd0;
   localparam logic [1:0] PH_WAIT   = 2'd1;
   localparam logic [1:0] PH_QUEUED = 2'd2;
   localparam logic [1:0] PH_RUN    = 2'd3;

   // Request kinds.
   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_LOADED = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_RAN    = 2'd2;
   localparam logic [1:0] ST_IDLE   = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_QUANTUM = 1'b0;
   localparam logic CSR_AGING   = 1'b1;

   localparam logic [15:0] QUANTUM_RESET = 16'd4;
   localparam logic [15:0] AGING_RESET   = 16'd10;

   // Priority floor.
   localparam logic signed [16:0] PRIO_MIN = -17'sd32768;

   typedef struct packed {
      logic [7:0]         id;
      logic [15:0]        arrival;
      logic [15:0]        remaining;
      logic signed [16:0] prio;
      logic [31:0]        last_run;
   } entry_type;

   typedef struct packed {
      logic      main_we;
      logic      order_we;
      entry_type entry;
      logic [15:0] order;
   } tbl_wr_type;

endpackage

`default_nettype wire

/* sv/prs_table.sv */
// ---------------------------------------------------------------------------
// prs_table: process table storage
// Two synchronous memories, entry record and enqueue order, one read port
// with registered data and one write port.
// ---------------------------------------------------------------------------
`default_nettype none

module prs_table import prs_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      entry_type                rd_entry,
   output      logic [15:0]              rd_order,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire tbl_wr_type               wr
);

   entry_type   entry_mem [DEPTH];
   logic [15:0] order_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.main_we) begin
         entry_mem[wr_addr] <= wr.entry;
      end
      if (wr.order_we) begin
         order_mem[wr_addr] <= wr.order;
      end
      rd_entry <= entry_mem[rd_addr];
      rd_order <= order_mem[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/prs_ctrl.sv */
// ---------------------------------------------------------------------------
// prs_ctrl: scheduler sequencer
// Handles loads, slice steps and the admit, select and aging passes over the
// table, and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module prs_ctrl import prs_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic        req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,
   output      logic [1:0]  rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [15:0] csr_wdata,
   output      logic [$clog2(MAX_PROCS)-1:0] tbl_rd_addr,
   input  wire entry_type                    tbl_rd_entry,
   input  wire logic [15:0]                  tbl_rd_order,
   output      logic [$clog2(MAX_PROCS)-1:0] tbl_wr_addr,
   output      tbl_wr_type                   tbl_wr
);

   localparam int IW = $clog2(MAX_PROCS);
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ADM_RD = 4'd1;
   localparam logic [3:0] S_ADM_EX = 4'd2;
   localparam logic [3:0] S_SEL_RD = 4'd3;
   localparam logic [3:0] S_SEL_EX = 4'd4;
   localparam logic [3:0] S_PICK   = 4'd5;
   localparam logic [3:0] S_RUN_RD = 4'd6;
   localparam logic [3:0] S_RUN_EX = 4'd7;
   localparam logic [3:0] S_REQ    = 4'd8;
   localparam logic [3:0] S_AGE_RD = 4'd9;
   localparam logic [3:0] S_AGE_EX = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [1:0]  phase_ff [MAX_PROCS];
   logic [1:0]  phase_in [MAX_PROCS];
   logic [31:0] now_ff, now_in;
   logic [15:0] slice_ff, slice_in;
   logic [IW-1:0] run_ff, run_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] quantum_ff, quantum_in;
   logic [15:0] aging_ff, aging_in;
   logic        adm_end_ff, adm_end_in;
   logic        found_ff, found_in;
   logic [IW-1:0] best_ff, best_in;
   logic signed [16:0] best_prio_ff, best_prio_in;
   logic [15:0] best_dist_ff, best_dist_in;
   logic [15:0] best_rem_ff, best_rem_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [7:0]  res_id_ff, res_id_in;
   logic        res_fin_ff, res_fin_in;
   logic [31:0] res_time_ff, res_time_in;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [47:0] out_data_ff, out_data_in;

   logic [IW-1:0] free_idx;
   logic          free_found;
   logic [1:0]    want_phase;
   logic [3:0]    pass_ex, pass_end;
   logic [15:0]   q_eff, order_gap, rem_dec, burst;
   entry_type     e_mod;

   // Lowest-numbered empty slot.
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = MAX_PROCS - 1; i >= 0; i--) begin
         if (phase_ff[i] == PH_EMPTY) begin
            free_idx   = IW'(i);
            free_found = 1'b1;
         end
      end
   end

   assign q_eff     = (quantum_ff == 16'd0) ? 16'd1 : quantum_ff;
   assign order_gap = cnt_ff - tbl_rd_order;
   assign rem_dec   = tbl_rd_entry.remaining - 16'd1;
   assign burst     = req_tdata[39:24];

   always_comb begin
      case (state_ff)
         S_ADM_RD: begin
            want_phase = PH_WAIT;
            pass_ex    = S_ADM_EX;
            pass_end   = adm_end_ff ? S_REQ : S_SEL_RD;
         end
         S_SEL_RD: begin
            want_phase = PH_QUEUED;
            pass_ex    = S_SEL_EX;
            pass_end   = S_PICK;
         end
         S_ADM_EX: begin
            want_phase = PH_WAIT;
            pass_ex    = S_ADM_RD;
            pass_end   = adm_end_ff ? S_REQ : S_SEL_RD;
         end
         S_SEL_EX: begin
            want_phase = PH_QUEUED;
            pass_ex    = S_SEL_RD;
            pass_end   = S_PICK;
         end
         S_AGE_EX: begin
            want_phase = PH_QUEUED;
            pass_ex    = S_AGE_RD;
            pass_end   = S_DONE;
         end
         default: begin
            want_phase = PH_QUEUED;
            pass_ex    = S_AGE_EX;
            pass_end   = S_DONE;
         end
      endcase
   end

   assign tbl_rd_addr = (state_ff == S_RUN_RD) ? run_ff : idx_ff;
   assign req_tready  = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      phase_in      = phase_ff;
      now_in        = now_ff;
      slice_in      = slice_ff;
      run_in        = run_ff;
      cnt_in        = cnt_ff;
      quantum_in    = quantum_ff;
      aging_in      = aging_ff;
      adm_end_in    = adm_end_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_prio_in  = best_prio_ff;
      best_dist_in  = best_dist_ff;
      best_rem_in   = best_rem_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_fin_in    = res_fin_ff;
      res_time_in   = res_time_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_data_in   = out_data_ff;
      tbl_wr        = '0;
      tbl_wr_addr   = idx_ff;
      e_mod         = tbl_rd_entry;

      if (csr_we) begin
         if (csr_addr == CSR_QUANTUM) begin
            quantum_in = csr_wdata;
         end else begin
            aging_in = csr_wdata;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == REQ_LOAD) begin
                  res_id_in   = '0;
                  res_fin_in  = 1'b0;
                  res_time_in = '0;
                  if (free_found) begin
                     res_status_in           = ST_LOADED;
                     tbl_wr_addr             = free_idx;
                     tbl_wr.main_we          = 1'b1;
                     tbl_wr.entry.id         = req_tdata[7:0];
                     tbl_wr.entry.arrival    = req_tdata[23:8];
                     tbl_wr.entry.remaining  = (burst == 16'd0) ? 16'd1 : burst;
                     tbl_wr.entry.prio       = {9'd0, req_tdata[47:40]};
                     tbl_wr.entry.last_run   = {16'd0, req_tdata[23:8]};
                     phase_in[free_idx]      = PH_WAIT;
                  end else begin
                     res_status_in = ST_FULL;
                  end
                  state_in = S_DONE;
               end else if (slice_ff == 16'd0) begin
                  adm_end_in = 1'b0;
                  found_in   = 1'b0;
                  idx_in     = '0;
                  state_in   = S_ADM_RD;
               end else begin
                  state_in = S_RUN_RD;
               end
            end
         end
         S_ADM_RD, S_SEL_RD, S_AGE_RD: begin
            if (phase_ff[idx_ff] == want_phase) begin
               state_in = pass_ex;
            end else if (idx_ff == LAST_IDX) begin
               state_in = pass_end;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_ADM_EX, S_SEL_EX, S_AGE_EX: begin
            if (state_ff == S_ADM_EX) begin
               if ({16'd0, tbl_rd_entry.arrival} <= now_ff) begin
                  phase_in[idx_ff] = PH_QUEUED;
                  tbl_wr.order_we  = 1'b1;
                  tbl_wr.order     = cnt_ff;
                  cnt_in           = cnt_ff + 16'd1;
               end
            end else if (state_ff == S_SEL_EX) begin
               if (!found_ff || (tbl_rd_entry.prio < best_prio_ff) ||
                   ((tbl_rd_entry.prio == best_prio_ff) && (order_gap > best_dist_ff))) begin
                  found_in     = 1'b1;
                  best_in      = idx_ff;
                  best_prio_in = tbl_rd_entry.prio;
                  best_dist_in = order_gap;
                  best_rem_in  = tbl_rd_entry.remaining;
               end
            end else begin
               if (((now_ff - tbl_rd_entry.last_run) > {16'd0, aging_ff}) &&
                   (tbl_rd_entry.prio != PRIO_MIN)) begin
                  e_mod.prio     = tbl_rd_entry.prio - 17'sd1;
                  tbl_wr.main_we = 1'b1;
                  tbl_wr.entry   = e_mod;
               end
            end
            if (idx_ff == LAST_IDX) begin
               state_in = pass_end;
               idx_in   = '0;
            end else begin
               state_in = pass_ex;
               idx_in   = idx_ff + 1'b1;
            end
         end
         S_PICK: begin
            if (!found_ff) begin
               res_status_in = ST_IDLE;
               res_id_in     = '0;
               res_fin_in    = 1'b0;
               res_time_in   = now_ff;
               now_in        = now_ff + 32'd1;
               idx_in        = '0;
               state_in      = S_AGE_RD;
            end else begin
               run_in            = best_ff;
               phase_in[best_ff] = PH_RUN;
               slice_in          = (best_rem_ff < q_eff) ? best_rem_ff : q_eff;
               state_in          = S_RUN_RD;
            end
         end
         S_RUN_RD: begin
            state_in = S_RUN_EX;
         end
         S_RUN_EX: begin
            res_status_in   = ST_RAN;
            res_id_in       = tbl_rd_entry.id;
            res_fin_in      = 1'b0;
            res_time_in     = now_ff;
            now_in          = now_ff + 32'd1;
            slice_in        = slice_ff - 16'd1;
            e_mod.remaining = rem_dec;
            tbl_wr_addr     = run_ff;
            tbl_wr.main_we  = 1'b1;
            idx_in          = '0;
            state_in        = S_DONE;
            if (slice_ff == 16'd1) begin
               e_mod.last_run = now_ff + 32'd1;
               if (rem_dec == 16'd0) begin
                  res_fin_in       = 1'b1;
                  phase_in[run_ff] = PH_EMPTY;
                  state_in         = S_AGE_RD;
               end else begin
                  adm_end_in = 1'b1;
                  state_in   = S_ADM_RD;
               end
            end
            tbl_wr.entry = e_mod;
         end
         S_REQ: begin
            // Requeue the slot that just ran behind the new arrivals.
            tbl_wr_addr      = run_ff;
            tbl_wr.order_we  = 1'b1;
            tbl_wr.order     = cnt_ff;
            cnt_in           = cnt_ff + 16'd1;
            phase_in[run_ff] = PH_QUEUED;
            idx_in           = '0;
            state_in         = S_AGE_RD;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_data_in   = {7'd0, res_time_ff, res_fin_ff, res_id_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         now_ff       <= '0;
         slice_ff     <= '0;
         run_ff       <= '0;
         cnt_ff       <= '0;
         quantum_ff   <= QUANTUM_RESET;
         aging_ff     <= AGING_RESET;
         adm_end_ff   <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_PROCS; i++) begin
            phase_ff[i] <= PH_EMPTY;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         now_ff       <= now_in;
         slice_ff     <= slice_in;
         run_ff       <= run_in;
         cnt_ff       <= cnt_in;
         quantum_ff   <= quantum_in;
         aging_ff     <= aging_in;
         adm_end_ff   <= adm_end_in;
         found_ff     <= found_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
      best_ff       <= best_in;
      best_prio_ff  <= best_prio_in;
      best_dist_ff  <= best_dist_in;
      best_rem_ff   <= best_rem_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_fin_ff    <= res_fin_in;
      res_time_ff   <= res_time_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

/* sv/priority_rr_scheduler_with_aging.sv */
// ---------------------------------------------------------------------------
// priority_rr_scheduler_with_aging: priority scheduler with aging
// Top level: process table memories plus the scheduling sequencer.
// ---------------------------------------------------------------------------
// The block keeps a table of MAX_PROCS processes. A load item stores a
// process in the lowest free slot and answers loaded or table full. Each
// advance item is one time unit and answers which process ran, or idle. An
// advance inside a slice that goes on reads the running entry, writes it
// back and then fills the result stage. At a slice boundary the sequencer
// walks the table once to admit arrived processes and once to pick the
// lowest priority value (the earliest enqueued wins a tie). When a slice
// ends without completing its process, one more walk admits the processes
// that arrived meanwhile ahead of the requeued one, and after every slice
// end or idle unit a last walk ages the queued processes. A walk only checks
// the phase of a slot that takes no part, and does a memory read, then
// modify and write, for one that does; with the single read port of the
// table the walks visit the slots one at a time. The next item is accepted
// once the previous one is in the result register, even while that result
// still waits to be taken.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_rr_scheduler_with_aging import prs_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // proc_id [7:0], arrival_at [23:8], burst_length [39:24], start_priority [47:40]
   input  wire logic [47:0] req_tdata,
   // req_type [0]
   input  wire logic        req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // ran_id [7:0], finished [8], unit_time [40:9], zero fill [47:41]
   output      logic [47:0] rsp_tdata,
   // status [1:0]
   output      logic [1:0]  rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [15:0] csr_wdata
);

   localparam int IW = $clog2(MAX_PROCS);

   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   entry_type     rd_entry;
   logic [15:0]   rd_order;
   tbl_wr_type    wr;

   prs_table #(.DEPTH(MAX_PROCS)) u_table (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_order (rd_order),
      .wr_addr  (wr_addr),
      .wr       (wr)
   );

   prs_ctrl #(.MAX_PROCS(MAX_PROCS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .tbl_rd_addr  (rd_addr),
      .tbl_rd_entry (rd_entry),
      .tbl_rd_order (rd_order),
      .tbl_wr_addr  (wr_addr),
      .tbl_wr       (wr)
   );

endmodule

`default_nettype wire

/* sv/prs_checker.sv */
// ---------------------------------------------------------------------------
// prs_checker: port checks of the scheduler
// Watches the top level ports and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module prs_checker import prs_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_load_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_LOADED || rsp_tuser == ST_FULL) |-> rsp_tdata == 48'd0)
      else $error("load result carries data");

   a_fin_ran: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tuser == ST_RAN)
      else $error("finished without a run");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while the previous one is in work");

endmodule

bind priority_rr_scheduler_with_aging prs_checker u_prs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* tb/priority_rr_scheduler_with_aging_test.sv */
// ---------------------------------------------------------------------------
// priority_rr_scheduler_with_aging_test: self-checking scheduler testbench
// Drives load and advance items through the request stream, predicts results
// with a behavioral scheduler model or takes them from the directed table, and compares each returned item.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module priority_rr_scheduler_with_aging_test;
   import prs_pkg::*;

   localparam int NSLOT       = 16;
   localparam int CYCLE_LIMIT = 1500000;
   // An item walks the table up to four times, so this covers the slowest
   // item with a wide margin.
   localparam int SETTLE      = 200;
   localparam int PHASE_ITEMS = 432;
   localparam int NPHASE      = 4;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  ran_id;
      logic        finished;
      logic [31:0] unit_time;
   } sched_result_type;

   typedef struct {
      logic             kind;
      logic [7:0]       id;
      logic [15:0]      arrival;
      logic [15:0]      burst;
      logic [7:0]       prio;
      bit               typed;
      sched_result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire  logic  req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = REQ_LOAD;
   wire  logic  rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  logic [47:0] rsp_tdata;
   wire  logic [1:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_QUANTUM;
   logic [15:0] csr_wdata = '0;

   // When set, neither side inserts idle cycles.
   bit calm = 1'b0;
   int error_count = 0;
   int cycle_count = 0;

   sched_result_type unit_q[$];

   priority_rr_scheduler_with_aging #(.MAX_PROCS(NSLOT)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Scheduler prediction: a private copy of the process table and timers.
   // -------------------------------------------------------------------------
   logic [7:0]  tab_id[NSLOT];
   logic [15:0] tab_arrival[NSLOT];
   logic [15:0] tab_left[NSLOT];
   int          tab_prio[NSLOT];
   logic [31:0] tab_last[NSLOT];
   logic [1:0]  tab_phase[NSLOT];
   logic [15:0] tab_order[NSLOT];
   logic [31:0] clk_now = '0;
   logic [15:0] slice_cnt = '0;
   int          run_slot = 0;
   logic [15:0] order_cnt = '0;
   logic [15:0] cfg_quantum = QUANTUM_RESET;
   logic [15:0] cfg_aging = AGING_RESET;

   initial begin
      foreach (tab_phase[i]) tab_phase[i] = PH_EMPTY;
   end

   function automatic void put_in_queue(input int s);
      tab_phase[s] = PH_QUEUED;
      tab_order[s] = order_cnt;
      order_cnt = order_cnt + 16'd1;
   endfunction

   // Every loaded process whose arrival time has come joins the queue,
   // in slot order.
   function automatic void admit_arrived();
      for (int s = 0; s < NSLOT; s++)
         if (tab_phase[s] == PH_WAIT && {16'd0, tab_arrival[s]} <= clk_now)
            put_in_queue(s);
   endfunction

   // Queued processes that waited past the threshold move one step up.
   function automatic void age_waiting();
      for (int s = 0; s < NSLOT; s++)
         if (tab_phase[s] == PH_QUEUED && (clk_now - tab_last[s]) > {16'd0, cfg_aging}
             && tab_prio[s] > -32768)
            tab_prio[s] = tab_prio[s] - 1;
   endfunction

   function automatic sched_result_type schedule_step(input logic kind, input logic [7:0] id,
         input logic [15:0] arrival, input logic [15:0] burst, input logic [7:0] prio);
      sched_result_type r;
      int               s;
      int               best;
      bit               found;
      logic [15:0]      q;
      logic [15:0]      wait_s;
      logic [15:0]      wait_b;
      r = '0;
      if (kind == REQ_LOAD) begin
         s = 0;
         while (s < NSLOT && tab_phase[s] != PH_EMPTY) s++;
         if (s == NSLOT) begin
            r.status = ST_FULL;
            return r;
         end
         tab_id[s]      = id;
         tab_arrival[s] = arrival;
         tab_left[s]    = (burst == 16'd0) ? 16'd1 : burst;
         tab_prio[s]    = int'(prio);
         tab_last[s]    = {16'd0, arrival};
         tab_order[s]   = '0;
         tab_phase[s]   = PH_WAIT;
         r.status = ST_LOADED;
         return r;
      end
      if (slice_cnt == 16'd0) begin
         admit_arrived();
         found = 1'b0;
         best  = 0;
         for (s = 0; s < NSLOT; s++) begin
            if (tab_phase[s] != PH_QUEUED) continue;
            if (!found) begin
               best  = s;
               found = 1'b1;
            end else if (tab_prio[s] < tab_prio[best]) begin
               best = s;
            end else if (tab_prio[s] == tab_prio[best]) begin
               // Equal priority: the one furthest behind the counter was
               // enqueued first and wins.
               wait_s = order_cnt - tab_order[s];
               wait_b = order_cnt - tab_order[best];
               if (wait_s > wait_b) best = s;
            end
         end
         if (!found) begin
            r.status    = ST_IDLE;
            r.unit_time = clk_now;
            clk_now     = clk_now + 1;
            age_waiting();
            return r;
         end
         q = (cfg_quantum == 16'd0) ? 16'd1 : cfg_quantum;
         run_slot = best;
         tab_phase[best] = PH_RUN;
         slice_cnt = (tab_left[best] < q) ? tab_left[best] : q;
      end
      s = run_slot;
      r.status    = ST_RAN;
      r.ran_id    = tab_id[s];
      r.unit_time = clk_now;
      clk_now     = clk_now + 1;
      tab_left[s] = tab_left[s] - 16'd1;
      slice_cnt   = slice_cnt - 16'd1;
      if (slice_cnt == 16'd0) begin
         tab_last[s] = clk_now;
         if (tab_left[s] == 16'd0) begin
            r.finished   = 1'b1;
            tab_phase[s] = PH_EMPTY;
         end else begin
            // Newcomers of this slice get in line ahead of the preempted one.
            admit_arrived();
            put_in_queue(s);
         end
         age_waiting();
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Mismatch reporting and the result checker.
   // -------------------------------------------------------------------------
   task automatic report(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      sched_result_type got;
      sched_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tuser;
            got.ran_id    = rsp_tdata[7:0];
            got.finished  = rsp_tdata[8];
            got.unit_time = rsp_tdata[40:9];
            if (unit_q.size() == 0) begin
               report($sformatf("unexpected result item status %0d", got.status));
            end else begin
               want = unit_q.pop_front();
               if (got.status != want.status)
                  report($sformatf("status %0d, expected %0d", got.status, want.status));
               if (got.ran_id != want.ran_id)
                  report($sformatf("ran_id %0d, expected %0d", got.ran_id, want.ran_id));
               if (got.finished != want.finished)
                  report($sformatf("finished %0b, expected %0b", got.finished,
                                   want.finished));
               if (got.unit_time != want.unit_time)
                  report($sformatf("unit_time %0d, expected %0d", got.unit_time,
                                   want.unit_time));
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 36);
      end
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sender side. Tasks are entered right after a rising edge.
   // -------------------------------------------------------------------------
   task automatic send_item(input logic kind, input logic [7:0] id, input logic [15:0] arrival,
         input logic [15:0] burst, input logic [7:0] prio, input bit typed,
         input sched_result_type want);
      sched_result_type predicted;
      while (!calm && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {prio, burst, arrival, id};
      do @(posedge clock); while (!req_tready);
      // Accepted at this edge; the table copy moves on even for typed rows.
      predicted = schedule_step(kind, id, arrival, burst, prio);
      unit_q = {unit_q, (typed ? want : predicted)};
   endtask

   task automatic write_csr(input logic addr, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_QUANTUM) cfg_quantum = value;
      else cfg_aging = value;
      @(posedge clock);
   endtask

   // Lets the block run dry so that a register write lands while it is idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (unit_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   stim_row_type rows[$];

   initial begin
      stim_row_type     row;
      sched_result_type none;
      logic [15:0]      quanta[NPHASE];
      logic [15:0]      agings[NPHASE];
      int               busy;
      logic             kind;
      logic [15:0]      arrival;
      logic [15:0]      burst;

      // Setting per random phase: shortest and longest slices and aging
      // limits, including a quantum of zero that must behave as one.
      quanta = '{16'd1, 16'd65535, 16'd0, 16'd3};
      agings = '{16'd0, 16'd65535, 16'd3, 16'd25};
      none = '0;

      // Directed table. First an advance into an empty table: idle at time 0.
      row = '{REQ_ADVANCE, 8'd0, 16'd0, 16'd0, 8'd0, 1'b1, '{ST_IDLE, 8'd0, 1'b0, 32'd0}};
      rows = {rows, row};
      // Id zero with a zero burst, stored as a one-unit burst.
      row = '{REQ_LOAD, 8'd0, 16'd0, 16'd0, 8'd255, 1'b1, none};
      rows = {rows, row};
      // All-ones id, arrival and burst; the arrival never comes within this run.
      row = '{REQ_LOAD, 8'd255, 16'd65535, 16'd65535, 8'd0, 1'b1, none};
      rows = {rows, row};
      // Duplicate id.
      row = '{REQ_LOAD, 8'd0, 16'd0, 16'd3, 8'd0, 1'b1, none};
      rows = {rows, row};
      // Fill the rest of the table with equal priorities to show round robin.
      for (int k = 1; k <= 13; k++) begin
         row = '{REQ_LOAD, 8'(k), 16'(k % 3), 16'(1 + k % 2), 8'd128, 1'b1, none};
         rows = {rows, row};
      end
      // One more load finds every slot taken.
      row = '{REQ_LOAD, 8'd77, 16'd0, 16'd1, 8'd1, 1'b1, '{ST_FULL, 8'd0, 1'b0, 32'd0}};
      rows = {rows, row};
      for (int k = 0; k < 6; k++) begin
         row = '{REQ_ADVANCE, 8'hA5, 16'h5A5A, 16'hFFFF, 8'hFF, 1'b0, none};
         rows = {rows, row};
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_item(rows[i].kind, rows[i].id, rows[i].arrival, rows[i].burst, rows[i].prio,
                   rows[i].typed, rows[i].want);

      for (int ph = 0; ph < NPHASE; ph++) begin
         // The sender waits here until every expected result is back.
         drain();
         write_csr(CSR_QUANTUM, quanta[ph]);
         write_csr(CSR_AGING, agings[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            calm = (ph == 2 && n < 300);
            busy = 0;
            foreach (tab_phase[s]) if (tab_phase[s] != PH_EMPTY) busy++;
            // Loads about 30 percent of the time while there is room, else a few that may find the table full.
            kind = ((busy < NSLOT - 1 && $urandom_range(99) < 30) || $urandom_range(99) < 3)
                   ? REQ_LOAD : REQ_ADVANCE;
            arrival = 16'(clk_now + $urandom_range(20));
            burst = ($urandom_range(99) < 4) ? 16'($urandom_range(300, 1))
                                            : 16'($urandom_range(10, 1));
            send_item(kind, 8'($urandom), arrival, burst, 8'($urandom), 1'b0, none);
         end
      end
      calm = 1'b0;

      drain();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
